// File: sv/tkhs_pkg.sv
// Shared constants, codes and field positions of the touch key hysteresis scanner.
package tkhs_pkg;

   localparam int DEF_CHANNELS = 8;
   localparam int DEF_WINDOW   = 20;

   localparam int CHAN_W  = 3;
   localparam int LEVEL_W = 10;
   localparam int DATA_W  = 24;

   localparam logic [LEVEL_W-1:0] MARGIN_RESET = 10'd150;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 10'd1023;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 10'd1;

   // Request beat layout.
   localparam int REQ_CH_LSB  = 0;
   localparam int REQ_SMP_LSB = REQ_CH_LSB + CHAN_W;
   localparam int REQ_REF_LSB = REQ_SMP_LSB + LEVEL_W;

   // Response beat layout.
   localparam int RSP_CH_LSB  = 0;
   localparam int RSP_AVG_LSB = RSP_CH_LSB + CHAN_W;
   localparam int RSP_PRS_BIT = RSP_AVG_LSB + LEVEL_W;
   localparam int RSP_EV_LSB  = RSP_PRS_BIT + 1;
   localparam int RSP_ANY_BIT = RSP_EV_LSB + 2;
   localparam int RSP_USED_W  = RSP_ANY_BIT + 1;

   typedef enum logic [1:0] {
      KEY_NONE    = 2'd0,
      KEY_PRESS   = 2'd1,
      KEY_RELEASE = 2'd2
   } key_event_type;

endpackage

// File: sv/touch_key_hysteresis_scanner_unit.sv
// Touch key scanner: per-channel moving average and hysteresis press detection.
//
// Usage: each request beat carries one converter sample for one touch channel
// together with the reference level of the band. The block folds the sample into
// that channel's moving-average window (up to WINDOW samples), divides the window
// sum by the number of samples held, rounding half up, and compares the average
// against the band [max(ref - margin, 1), min(ref + margin, 1023)]. Below the band
// the key is pressed, above it released, inside it keeps its state. Every request
// beat yields exactly one response beat with the channel, the average, the pressed
// state, a press or release event and the OR of all pressed flags. A channel number
// at or above CHANNELS changes nothing and reports a zero average, pressed and event.
// Steps and flow: one item is in flight at a time. A response is loaded after the
// request beat passes the record read, window read and write-back, reciprocal
// multiply and compare steps; no new request is taken until the item is done, a
// pace set by the two dependent reads of the record and window RAMs.
// A new request is taken while the previous response still waits in the output
// register; if the receiver stalls, the finished item waits in its last step.
// Reset marks all windows and counts empty, clears all pressed flags and sets the margin
// to 150; the margin register may be written only while the block is idle.
module touch_key_hysteresis_scanner_unit #(
   parameter int CHANNELS = tkhs_pkg::DEF_CHANNELS,
   parameter int WINDOW   = tkhs_pkg::DEF_WINDOW
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request: channel [2:0], sample [12:3], reference_level [22:13], zero [23].
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tkhs_pkg::DATA_W-1:0] req_tdata,
   // Response: out_channel [2:0], average [12:3], pressed [13], key_event [15:14],
   // any_pressed [16], zero [23:17].
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tkhs_pkg::DATA_W-1:0] rsp_tdata,
   // Hysteresis margin register.
   input  logic                        csr_wr_en,
   input  logic [tkhs_pkg::LEVEL_W-1:0] csr_wr_data
);

   localparam int LW     = tkhs_pkg::LEVEL_W;
   localparam int CW     = tkhs_pkg::CHAN_W;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
   localparam int NUM_W  = SUM_W + 1;
   // Reciprocal precision: numerator times (divisor - 1) stays below 2**K, which
   // makes the truncated product equal to the exact quotient.
   localparam int K      = NUM_W + CNT_W;
   localparam int R_W    = K + 1;
   localparam int PROD_W = NUM_W + R_W;
   localparam int WIN_D  = CHANNELS * WINDOW;
   localparam int WA_W   = (WIN_D > 1) ? $clog2(WIN_D) : 1;
   localparam int REC_W  = SLOT_W + CNT_W + SUM_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REC,
      S_WIN,
      S_MUL,
      S_FIN
   } state_type;

   // Reciprocal table indexed by the fill count.
   logic [R_W-1:0] recip_tab [WINDOW + 1];

   assign recip_tab[0] = '0;
   for (genvar d = 1; d <= WINDOW; d++) begin : g_recip
      localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(d) - 64'd1) / 64'(d);
      assign recip_tab[d] = RECIP[R_W-1:0];
   end

   state_type         state_ff, state_in;
   logic [CW-1:0]     ch_ff, ch_in;
   logic [LW-1:0]     sample_ff, sample_in;
   logic [LW-1:0]     ref_ff, ref_in;
   logic              bad_ff, bad_in;
   logic [LW-1:0]     margin_ff, margin_in;
   logic [CHANNELS-1:0] rec_valid_ff, rec_valid_in;
   logic [CHANNELS-1:0] pressed_ff, pressed_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WA_W-1:0]   waddr_ff, waddr_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [tkhs_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic              rec_wr_en, rec_rd_en;
   logic [CH_W-1:0]   rec_rd_addr, ch_idx;
   logic [REC_W-1:0]  rec_wr_data, rec_rd_data;
   logic              win_wr_en, win_rd_en;
   logic [LW-1:0]     win_rd_data;

   // Combinational helpers.
   logic              req_fire;
   logic [CW-1:0]     req_ch;
   logic              rec_ok;
   logic [SLOT_W-1:0] rec_slot;
   logic              full;
   logic [SUM_W:0]    sum_add;
   logic [SUM_W-1:0]  new_sum;
   logic [CNT_W-1:0]  new_fill;
   logic [SLOT_W-1:0] new_slot;
   logic [LW-1:0]     avg;
   logic [LW-1:0]     lower, upper;
   logic [LW:0]       upper_raw;
   logic              prev, cur;
   tkhs_pkg::key_event_type ev;
   logic [CHANNELS-1:0] pressed_nx;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_ch     = req_tdata[tkhs_pkg::REQ_CH_LSB +: CW];
   assign ch_idx     = CH_W'(ch_ff);
   assign rec_rd_addr = CH_W'(req_ch);

   assign rec_ok   = rec_valid_ff[ch_idx];
   assign rec_slot = rec_rd_data[SUM_W + CNT_W +: SLOT_W];

   // Window update arithmetic, used in the write-back step.
   assign full     = (32'(fill_ff) == WINDOW);
   assign sum_add  = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(sample_ff);
   assign new_sum  = full ? SUM_W'(sum_add - (SUM_W + 1)'(win_rd_data)) : SUM_W'(sum_add);
   assign new_fill = full ? fill_ff : fill_ff + 1'b1;
   assign new_slot = (32'(slot_ff) == WINDOW - 1) ? '0 : slot_ff + 1'b1;
   assign rec_wr_data = {new_slot, new_fill, new_sum};

   // Hysteresis band and decision, used in the final step.
   assign avg       = prod_ff[K +: LW];
   assign lower     = (ref_ff <= margin_ff) ? tkhs_pkg::LEVEL_MIN : ref_ff - margin_ff;
   assign upper_raw = (LW + 1)'(ref_ff) + (LW + 1)'(margin_ff);
   assign upper     = upper_raw[LW] ? tkhs_pkg::LEVEL_MAX : upper_raw[LW-1:0];
   assign prev      = pressed_ff[ch_idx];

   always_comb begin
      cur = prev;
      // An empty band lets the pressed test win.
      priority if (avg < lower) begin
         cur = 1'b1;
      end else if (avg > upper) begin
         cur = 1'b0;
      end else begin
         cur = prev;
      end
      ev = tkhs_pkg::KEY_NONE;
      if (!bad_ff && cur != prev) begin
         ev = cur ? tkhs_pkg::KEY_PRESS : tkhs_pkg::KEY_RELEASE;
      end
      pressed_nx = pressed_ff;
      if (!bad_ff) begin
         pressed_nx[ch_idx] = cur;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      ref_in       = ref_ff;
      bad_in       = bad_ff;
      margin_in    = csr_wr_en ? csr_wr_data : margin_ff;
      rec_valid_in = rec_valid_ff;
      pressed_in   = pressed_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      waddr_in     = waddr_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rec_rd_en    = 1'b0;
      rec_wr_en    = 1'b0;
      win_rd_en    = 1'b0;
      win_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ch_in     = req_ch;
               sample_in = req_tdata[tkhs_pkg::REQ_SMP_LSB +: LW];
               ref_in    = req_tdata[tkhs_pkg::REQ_REF_LSB +: LW];
               bad_in    = (32'(req_ch) >= CHANNELS);
               rec_rd_en = 1'b1;
               state_in  = (32'(req_ch) >= CHANNELS) ? S_FIN : S_REC;
            end
         end
         S_REC: begin
            // The record arrives; a channel never written reads as empty.
            sum_in    = rec_ok ? rec_rd_data[SUM_W-1:0] : '0;
            fill_in   = rec_ok ? rec_rd_data[SUM_W +: CNT_W] : '0;
            slot_in   = (rec_ok && 32'(rec_slot) < WINDOW) ? rec_slot : '0;
            waddr_in  = WA_W'(32'(ch_idx) * WINDOW
                        + ((rec_ok && 32'(rec_slot) < WINDOW) ? 32'(rec_slot) : 0));
            win_rd_en = 1'b1;
            state_in  = S_WIN;
         end
         S_WIN: begin
            // The oldest sample arrives; it is only used once the window is full.
            rec_wr_en = 1'b1;
            win_wr_en = 1'b1;
            rec_valid_in[ch_idx] = 1'b1;
            num_in   = NUM_W'(new_sum) + NUM_W'(new_fill >> 1);
            div_in   = new_fill;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(num_ff) * PROD_W'(recip_tab[div_ff]);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               pressed_in   = pressed_nx;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[tkhs_pkg::RSP_CH_LSB +: CW]  = ch_ff;
               rsp_data_in[tkhs_pkg::RSP_AVG_LSB +: LW] = bad_ff ? '0 : avg;
               rsp_data_in[tkhs_pkg::RSP_PRS_BIT]       = !bad_ff && cur;
               rsp_data_in[tkhs_pkg::RSP_EV_LSB +: 2]   = ev;
               rsp_data_in[tkhs_pkg::RSP_ANY_BIT]       = |pressed_nx;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         margin_ff    <= tkhs_pkg::MARGIN_RESET;
         rec_valid_ff <= '0;
         pressed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         margin_ff    <= margin_in;
         rec_valid_ff <= rec_valid_in;
         pressed_ff   <= pressed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      ref_ff      <= ref_in;
      bad_ff      <= bad_in;
      sum_ff      <= sum_in;
      fill_ff     <= fill_in;
      slot_ff     <= slot_in;
      waddr_ff    <= waddr_in;
      num_ff      <= num_in;
      div_ff      <= div_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-channel record: write slot, fill count and window sum.
   tkhs_ram #(
      .WIDTH (REC_W),
      .DEPTH (CHANNELS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (ch_idx),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   // Window samples, WINDOW entries per channel.
   tkhs_ram #(
      .WIDTH (LW),
      .DEPTH (WIN_D)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (waddr_ff),
      .wr_data (sample_ff),
      .rd_en   (win_rd_en),
      .rd_addr (waddr_in),
      .rd_data (win_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/tkhs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module tkhs_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/tkhs_checker.sv
// Port-level checker for the touch key scanner, bound to the top level.
module tkhs_checker #(
   parameter int CHANNELS = tkhs_pkg::DEF_CHANNELS
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tkhs_pkg::DATA_W-1:0] rsp_tdata
);

   logic [1:0] ev;
   logic       prs;
   logic       any;

   assign ev  = rsp_tdata[tkhs_pkg::RSP_EV_LSB +: 2];
   assign prs = rsp_tdata[tkhs_pkg::RSP_PRS_BIT];
   assign any = rsp_tdata[tkhs_pkg::RSP_ANY_BIT];

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // The event code agrees with the reported state.
   a_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ev == tkhs_pkg::KEY_NONE)
                  || (ev == tkhs_pkg::KEY_PRESS && prs)
                  || (ev == tkhs_pkg::KEY_RELEASE && !prs))
      else $error("key event inconsistent with pressed state");

   // A pressed channel shows in the summary flag.
   a_any: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && prs |-> any)
      else $error("pressed channel missing from summary flag");

   // Unknown channels report a zero average, no press and no event.
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (32'(rsp_tdata[tkhs_pkg::RSP_CH_LSB +: tkhs_pkg::CHAN_W]) >= CHANNELS)
      |-> rsp_tdata[tkhs_pkg::RSP_AVG_LSB +: tkhs_pkg::LEVEL_W] == '0
          && !prs && ev == tkhs_pkg::KEY_NONE)
      else $error("out-of-range channel reported nonzero result");

endmodule

bind touch_key_hysteresis_scanner_unit tkhs_checker #(
   .CHANNELS (CHANNELS)
) u_tkhs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/touch_key_report_checker.sv
// Watches the touch scanner's channels, predicts every report and compares it.
module touch_key_report_checker
   import tkhs_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS,
   parameter int WINDOW   = DEF_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [DATA_W-1:0]   rsp_tdata,
   input  logic                csr_wr_en,
   input  logic [LEVEL_W-1:0]  csr_wr_data,
   output int unsigned         mismatch_count,
   output int unsigned         reports_outstanding
);

   typedef struct {
      logic [CHAN_W-1:0]  chan;
      logic [LEVEL_W-1:0] avg;
      logic               down;
      key_event_type      change;
      logic               any_down;
   } touch_report_t;

   logic [LEVEL_W-1:0] win_samples [CHANNELS][WINDOW];
   int unsigned        win_total [CHANNELS];
   int unsigned        held [CHANNELS];
   int unsigned        next_slot [CHANNELS];
   logic               key_down [CHANNELS];
   logic [LEVEL_W-1:0] band_margin;
   touch_report_t      awaited_reports [$];
   int unsigned        faults = 0;

   // Folds one sample into its channel's window and derives the report.
   function automatic touch_report_t fold_sample(input logic [CHAN_W-1:0] ch,
                                                 input logic [LEVEL_W-1:0] smp,
                                                 input logic [LEVEL_W-1:0] lvl);
      touch_report_t rep;
      int unsigned   slot;
      int unsigned   mean;
      int            lo;
      int            hi;
      logic          was_down;
      rep.chan     = ch;
      rep.avg      = '0;
      rep.down     = 1'b0;
      rep.change   = KEY_NONE;
      rep.any_down = 1'b0;
      if (int'(ch) < CHANNELS) begin
         slot = next_slot[ch];
         if (slot >= WINDOW) slot = 0;
         if (held[ch] < WINDOW) begin
            win_total[ch] += smp;
            held[ch]++;
         end else begin
            win_total[ch] = win_total[ch] - win_samples[ch][slot] + smp;
         end
         win_samples[ch][slot] = smp;
         next_slot[ch] = (slot + 1 >= WINDOW) ? 0 : slot + 1;
         mean = (win_total[ch] + held[ch] / 2) / held[ch];
         rep.avg = mean[LEVEL_W-1:0];
         lo = int'(lvl) - int'(band_margin);
         if (lo < int'(LEVEL_MIN)) lo = int'(LEVEL_MIN);
         hi = int'(lvl) + int'(band_margin);
         if (hi > int'(LEVEL_MAX)) hi = int'(LEVEL_MAX);
         // The press test comes first, so it wins when the band is empty.
         was_down = key_down[ch];
         if (int'(rep.avg) < lo) key_down[ch] = 1'b1;
         else if (int'(rep.avg) > hi) key_down[ch] = 1'b0;
         rep.down = key_down[ch];
         if (key_down[ch] != was_down) rep.change = key_down[ch] ? KEY_PRESS : KEY_RELEASE;
      end
      for (int c = 0; c < CHANNELS; c++) rep.any_down |= key_down[c];
      return rep;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      touch_report_t want;
      if (reset) begin
         band_margin = MARGIN_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            win_total[c] = 0;
            held[c]      = 0;
            next_slot[c] = 0;
            key_down[c]  = 1'b0;
         end
         awaited_reports.delete();
      end else begin
         if (csr_wr_en) band_margin = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_reports.size() == 0) begin
               $display("%0t: unexpected report beat, expected none, actual %h",
                        $time, rsp_tdata);
               faults++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("out_channel", want.chan, rsp_tdata[RSP_CH_LSB +: CHAN_W]);
               check_field("average", want.avg, rsp_tdata[RSP_AVG_LSB +: LEVEL_W]);
               check_field("pressed", want.down, rsp_tdata[RSP_PRS_BIT]);
               check_field("key_event", want.change, rsp_tdata[RSP_EV_LSB +: 2]);
               check_field("any_pressed", want.any_down, rsp_tdata[RSP_ANY_BIT]);
               check_field("padding", 0, rsp_tdata[DATA_W-1:RSP_USED_W]);
            end
         end
         if (req_tvalid && req_tready)
            awaited_reports.push_back(fold_sample(req_tdata[REQ_CH_LSB +: CHAN_W],
                                                  req_tdata[REQ_SMP_LSB +: LEVEL_W],
                                                  req_tdata[REQ_REF_LSB +: LEVEL_W]));
      end
      reports_outstanding <= awaited_reports.size();
      mismatch_count      <= faults;
   end

endmodule

// File: tb/touch_key_hysteresis_scanner_unit_test.sv
// Top of the touch scanner test: clock, reset, sample stimulus, stalls and verdict.
module touch_key_hysteresis_scanner_unit_test;
   import tkhs_pkg::*;

   // Eight phases of random beats, one margin setting per phase.
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 168;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                csr_wr_en;
   logic [LEVEL_W-1:0]  csr_wr_data;
   int unsigned         mismatch_count;
   int unsigned         reports_outstanding;

   // When calm is set, neither side inserts idle cycles any more.
   bit                  calm = 1'b0;
   // Level that each channel's samples drift around, and the phase's reference.
   logic [LEVEL_W-1:0]  aim [DEF_CHANNELS];
   logic [LEVEL_W-1:0]  base_ref;

   touch_key_hysteresis_scanner_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   touch_key_report_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mismatch_count      (mismatch_count),
      .reports_outstanding (reports_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The slowest correct run is near 1400 beats; this limit leaves roughly eight times
   // its run time.
   initial begin
      #4_000_000;
      $display("touch_key_hysteresis_scanner_unit_test: done, errors");
      $finish;
   end

   // Receiver: stalls at random between runs of readiness,
   // and stays ready for good once the run goes calm.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Offers one request beat and returns at the edge that accepts it. The valid
   // stays high afterwards, so back-to-back beats see no gap unless one is drawn.
   task automatic send_beat(input logic [CHAN_W-1:0] ch, input logic [LEVEL_W-1:0] smp,
                            input logic [LEVEL_W-1:0] lvl);
      logic [DATA_W-1:0] beat;
      beat = '0;
      beat[REQ_CH_LSB +: CHAN_W]   = ch;
      beat[REQ_SMP_LSB +: LEVEL_W] = smp;
      beat[REQ_REF_LSB +: LEVEL_W] = lvl;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops the valid and waits until every report the checker awaits has come
   // back. The checker publishes its count from a register, hence the first edge.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_outstanding != 0) @(posedge clock);
   endtask

   task automatic write_margin(input logic [LEVEL_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Most samples wander near a per-channel level that jumps now and then, so
   // the averages cross the band and produce presses and releases. The rest are
   // uniform noise and rail values.
   task automatic random_beat();
      logic [CHAN_W-1:0]  ch;
      logic [LEVEL_W-1:0] smp;
      logic [LEVEL_W-1:0] lvl;
      int                 pick;
      int                 noisy;
      ch = CHAN_W'($urandom_range(0, DEF_CHANNELS - 1));
      if ($urandom_range(0, 14) == 0) aim[ch] = LEVEL_W'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         noisy = int'(aim[ch]) + int'($urandom_range(0, 64)) - 32;
         if (noisy < 0) noisy = 0;
         if (noisy > int'(LEVEL_MAX)) noisy = int'(LEVEL_MAX);
         smp = LEVEL_W'(noisy);
      end else if (pick < 85) begin
         smp = LEVEL_W'($urandom_range(0, 1023));
      end else begin
         smp = $urandom_range(0, 1) ? LEVEL_MAX : '0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) lvl = base_ref;
      else if (pick < 90) lvl = LEVEL_W'($urandom_range(0, 1023));
      else lvl = $urandom_range(0, 1) ? LEVEL_MAX : '0;
      send_beat(ch, smp, lvl);
   endtask

   initial begin
      logic [LEVEL_W-1:0] margin;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      for (int c = 0; c < DEF_CHANNELS; c++) aim[c] = LEVEL_W'($urandom_range(0, 1023));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset margin. A zero reference pulls the lower
      // threshold up to its floor of 1; a full-scale reference clips the upper
      // threshold at 1023.
      send_beat(3'd0, 10'd0, 10'd0);         // average 0 under the floor: press
      send_beat(3'd0, LEVEL_MAX, 10'd0);     // average 512 above 150: release
      send_beat(3'd7, LEVEL_MAX, LEVEL_MAX); // on the clipped upper edge: hold
      send_beat(3'd7, 10'd0, LEVEL_MAX);     // average 512 below 873: press
      // A ramp across the band around 512 on channels 2 to 6 while their
      // windows are still filling.
      for (int i = 0; i < 16; i++)
         send_beat(CHAN_W'(2 + i % 5), LEVEL_W'(i * 68), 10'd512);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_reports();
         case (phase)
            0:       margin = '0;
            1:       margin = LEVEL_MAX;
            2:       margin = LEVEL_MIN;
            3:       margin = MARGIN_RESET;
            default: margin = LEVEL_W'($urandom_range(2, 300));
         endcase
         write_margin(margin);
         base_ref = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? LEVEL_MAX : '0)
                                               : LEVEL_W'($urandom_range(0, 1023));
         if (phase == 0) begin
            // Zero margin with a zero reference leaves the band empty: lower 1,
            // upper 0. Channel 1 is still fresh, so its average is the sample.
            send_beat(3'd1, 10'd0, 10'd0);
            send_beat(3'd1, LEVEL_MAX, 10'd0);
         end
         // The last phase runs with no idling on either side.
         if (phase == PHASES - 1) calm = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) random_beat();
      end

      drain_reports();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && reports_outstanding == 0) begin
         $display("touch_key_hysteresis_scanner_unit_test: done, clean");
      end else begin
         $display("touch_key_hysteresis_scanner_unit_test: done, errors");
      end
      $finish;
   end

endmodule
